// ===== design/mhdf_pkg.sv =====
package mhdf_pkg;

   // default number of segments in the map
   localparam int SEGMENTS_DEFAULT = 8;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int SEG_ID_W   = 4;
   localparam int SLOT_W     = 8;
   localparam int LOCAL_W    = 3;
   localparam int LENGTH_W   = 16;
   localparam int MAGIC_W    = 16;
   localparam int VERSION_W  = 8;
   localparam int HDR_SIZE_W = 8;
   localparam int SEQ_W      = 16;
   localparam int COUNT_W    = 32;

   // stream and register port widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE     = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_SLOT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HDR_SIZE   = 2'd3;

   localparam logic [HDR_SIZE_W-1:0] HDR_SIZE_RESET = 8'd8;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [SEG_ID_W-1:0]  seg_num;
      logic                 segment_used;
      logic [SLOT_W-1:0]    owner_slot;
      logic [LENGTH_W-1:0]  segment_length;
      logic [MAGIC_W-1:0]   hdr_magic;
      logic [VERSION_W-1:0] hdr_version;
      logic [SLOT_W-1:0]    hdr_source;
      logic [SLOT_W-1:0]    hdr_targets;
      logic [SEQ_W-1:0]     hdr_seq;
   } req_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_full;
      logic out_taken;
   } dp_status_type;

endpackage

// ===== design/mhdf_ctrl.sv =====
module mhdf_ctrl
   import mhdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic out_free;

   assign out_free  = !status.out_full || status.out_taken;
   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_ready && req_valid;
   assign cmd.exec  = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold the item until the output register can take its result
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/mhdf_datapath.sv =====
module mhdf_datapath
   import mhdf_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_item_type          req_item,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_accepted,
   output logic                  rsp_duplicate,
   output logic [COUNT_W-1:0]    rsp_scan_total,
   output logic [COUNT_W-1:0]    rsp_hit_total,
   output logic [COUNT_W-1:0]    rsp_duplicate_total
);

   localparam int IdxW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam logic [SEG_ID_W:0] SegLimit = (SEG_ID_W + 1)'(SEGMENTS);
   localparam logic [COUNT_W-1:0] CountStep = COUNT_W'(1);

   // configuration
   logic [LOCAL_W-1:0]    local_slot_ff;
   logic [MAGIC_W-1:0]    magic_ff;
   logic [VERSION_W-1:0]  version_ff;
   logic [HDR_SIZE_W-1:0] hdr_size_ff;

   // captured item
   req_item_type item_ff;

   // seen table
   logic [SEGMENTS-1:0] seen_ff;
   logic [SEQ_W-1:0]    last_seq_ff [SEGMENTS];

   logic [COUNT_W-1:0] scan_cnt_ff;
   logic [COUNT_W-1:0] hit_cnt_ff;
   logic [COUNT_W-1:0] dup_cnt_ff;
   logic [COUNT_W-1:0] scan_cnt_in;
   logic [COUNT_W-1:0] hit_cnt_in;
   logic [COUNT_W-1:0] dup_cnt_in;

   logic                rsp_valid_ff;
   logic                acc_ff;
   logic                dup_ff;
   logic                acc_in;
   logic                dup_in;
   logic                seen_set;
   logic                seen_clear;

   logic [IdxW-1:0]   idx;
   logic [SLOT_W-1:0] local_wide;
   logic              id_ok;
   logic              len_ok;
   logic              owner_local;
   logic              hdr_ok;
   logic              seen_hit;

   assign idx         = item_ff.seg_num[IdxW-1:0];
   assign local_wide  = {{(SLOT_W-LOCAL_W){1'b0}}, local_slot_ff};
   assign id_ok       = {1'b0, item_ff.seg_num} < SegLimit;
   assign len_ok      = item_ff.segment_length >= {{(LENGTH_W-HDR_SIZE_W){1'b0}}, hdr_size_ff};
   assign owner_local = item_ff.owner_slot == local_wide;
   assign hdr_ok      = id_ok && len_ok
                        && (item_ff.hdr_magic == magic_ff)
                        && (item_ff.hdr_version == version_ff)
                        && (item_ff.hdr_source == item_ff.owner_slot)
                        && (item_ff.hdr_source != local_wide)
                        && item_ff.hdr_targets[local_slot_ff];
   // table entry only counts once the segment has been marked seen
   assign seen_hit    = id_ok && seen_ff[idx] && (last_seq_ff[idx] == item_ff.hdr_seq);

   always_comb begin
      acc_in      = 1'b0;
      dup_in      = 1'b0;
      seen_set    = 1'b0;
      seen_clear  = 1'b0;
      scan_cnt_in = scan_cnt_ff;
      hit_cnt_in  = hit_cnt_ff;
      dup_cnt_in  = dup_cnt_ff;
      unique case (item_ff.func)
         FUNC_CLASSIFY: begin
            if (item_ff.segment_used && !owner_local && id_ok && len_ok) begin
               scan_cnt_in = scan_cnt_ff + CountStep;
               if (hdr_ok) begin
                  if (seen_hit) begin
                     dup_cnt_in = dup_cnt_ff + CountStep;
                     dup_in     = 1'b1;
                  end else begin
                     acc_in = 1'b1;
                  end
               end
            end
         end
         FUNC_COMMIT: begin
            if (item_ff.segment_used && hdr_ok) begin
               seen_set   = 1'b1;
               hit_cnt_in = hit_cnt_ff + CountStep;
               acc_in     = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            seen_clear = 1'b1;
         end
         FUNC_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         local_slot_ff <= '0;
         magic_ff      <= '0;
         version_ff    <= '0;
         hdr_size_ff   <= HDR_SIZE_RESET;
         seen_ff       <= '0;
         scan_cnt_ff   <= '0;
         hit_cnt_ff    <= '0;
         dup_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_LOCAL_SLOT: local_slot_ff <= csr_data[LOCAL_W-1:0];
               CSR_MAGIC:      magic_ff      <= csr_data[MAGIC_W-1:0];
               CSR_VERSION:    version_ff    <= csr_data[VERSION_W-1:0];
               CSR_HDR_SIZE:   hdr_size_ff   <= csr_data[HDR_SIZE_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.exec) begin
            scan_cnt_ff <= scan_cnt_in;
            hit_cnt_ff  <= hit_cnt_in;
            dup_cnt_ff  <= dup_cnt_in;
            if (seen_clear) begin
               seen_ff <= '0;
            end else if (seen_set) begin
               seen_ff[idx] <= 1'b1;
            end
         end
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      if (cmd.exec && seen_set) begin
         last_seq_ff[idx] <= item_ff.hdr_seq;
      end
      if (cmd.exec) begin
         acc_ff <= acc_in;
         dup_ff <= dup_in;
      end
   end

   assign status.out_full  = rsp_valid_ff;
   assign status.out_taken = rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_duplicate       = dup_ff;
   assign rsp_scan_total      = scan_cnt_ff;
   assign rsp_hit_total       = hit_cnt_ff;
   assign rsp_duplicate_total = dup_cnt_ff;

endmodule

// ===== design/mailbox_header_dedup_filter.sv =====
// mailbox header duplicate filter: each item is one request about one mailbox
// segment (map entry plus extracted header fields), with the request code on
// req_tuser (classify, commit, clear seen table). every item gives exactly one
// result with the accepted and duplicate flags and the three wrapping 32-bit
// counters as they stand after the item. an item is first captured into the
// item register; then the header is checked, the per-segment seen table read
// and updated and the output register loaded. a new item is only taken once
// the last one has been evaluated; a full output register holds the evaluate
// step. configuration writes on the csr port are meant for idle times only and
// are taken at once.
module mailbox_header_dedup_filter
   import mhdf_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,

   // request item stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // seg_num[3:0], segment_used[4], owner_slot[12:5], segment_length[28:13],
   // hdr_magic[44:29], hdr_version[52:45], hdr_source[60:53],
   // hdr_targets[68:61], hdr_seq[84:69], zero fill[87:85]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [FUNC_W-1:0]     req_tuser,

   // result item stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted[0], duplicate[1], scan_total[33:2], hit_total[65:34],
   // duplicate_total[97:66], zero fill[103:98]
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   // register write port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   req_item_type  req_item;
   dp_cmd_type    cmd;
   dp_status_type status;

   logic               acc;
   logic               dup;
   logic [COUNT_W-1:0] scan_total;
   logic [COUNT_W-1:0] hit_total;
   logic [COUNT_W-1:0] dup_total;

   // unpack the request item
   assign req_item.func           = req_tuser;
   assign req_item.seg_num        = req_tdata[3:0];
   assign req_item.segment_used   = req_tdata[4];
   assign req_item.owner_slot     = req_tdata[12:5];
   assign req_item.segment_length = req_tdata[28:13];
   assign req_item.hdr_magic      = req_tdata[44:29];
   assign req_item.hdr_version    = req_tdata[52:45];
   assign req_item.hdr_source     = req_tdata[60:53];
   assign req_item.hdr_targets    = req_tdata[68:61];
   assign req_item.hdr_seq        = req_tdata[84:69];

   // registers are always writable
   assign csr_ready = 1'b1;

   mhdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mhdf_datapath #(
      .SEGMENTS (SEGMENTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_item            (req_item),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_accepted        (acc),
      .rsp_duplicate       (dup),
      .rsp_scan_total      (scan_total),
      .rsp_hit_total       (hit_total),
      .rsp_duplicate_total (dup_total)
   );

   // pack the result item, first field lowest
   assign rsp_tdata = {6'd0, dup_total, hit_total, scan_total, dup, acc};

endmodule
